FILE: sv/rwhp_pkg.sv
package rwhp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [2:0]         error_code;
        logic [15:0]        channel_count;
        logic [30:0]        sample_rate;
        logic [1:0]         sample_width;
        logic [30:0]        frame_count;
        logic signed [15:0] sample_value;
        logic               end_of_data;
    } out_item_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
    localparam logic [2:0] ERR_NO_FMT    = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
    localparam logic [2:0] ERR_BAD_BITS  = 3'd4;
    localparam logic [2:0] ERR_NO_DATA   = 3'd5;
    localparam logic [2:0] ERR_ZERO      = 3'd6;
    localparam logic [2:0] ERR_NEG_LEN   = 3'd7;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // commands from controller to datapath
    typedef struct packed {
        logic shift_name;   // shift byte into chunk name
        logic shift_word;   // shift byte into gather word
        logic clear_word;
        logic cnt_clear;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_load_skip;
        logic cnt_load_excess;
        logic save_fmt_len;
        logic save_channels;
        logic save_rate;
        logic save_width;
        logic save_data_len;
        logic data_dec;
        logic hold_low;
        logic div_start;
        logic reset_all;
    } rwhp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [3:0]  cnt_low;       // low bits of byte counter
        logic        cnt_zero;
        logic        cnt_one;       // counter equals one
        logic        name_is_fmt;
        logic        name_is_data;
        logic        pre_ok;        // RIFF and WAVE both match
        logic        len_neg;       // next gather word bit 31
        logic        skip_zero;     // padded skip length is zero
        logic        fmt_tag_pcm;   // next word upper half == 1
        logic [15:0] next_upper;    // upper half of next gather word
        logic        fmt_long;      // format length > 16
        logic        width_two;
        logic        chan_zero;
        logic        data_one;      // data remaining equals one
        logic        data_zero;
        logic        cnt_odd;
        logic        div_busy;
        logic        div_done;
        logic        frames_zero;
    } rwhp_stat_t;

endpackage

FILE: sv/rwhp_divider.sv
module rwhp_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [16:0] shifted;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        shifted    = {rem_reg[15:0], quo_reg[31]};
        trial      = shifted - {1'b0, dvs_reg};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[16])
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: sv/rwhp_datapath.sv
module rwhp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  rwhp_pkg::rwhp_cmd_t cmd,
    output rwhp_pkg::rwhp_stat_t stat,
    output logic [15:0]         channels,
    output logic [31:0]         rate,
    output logic [1:0]          width,
    output logic [31:0]         frames,
    output logic [7:0]          low_byte
);
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] name_reg, name_next;
    logic [30:0] flen_reg, flen_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [1:0]  width_reg, width_next;
    logic [30:0] drem_reg, drem_next;
    logic [7:0]  low_reg, low_next;
    logic [31:0] word_shift;
    logic [31:0] name_shift;
    logic [31:0] skip_len;
    logic [31:0] len_by_width;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_quo;

    assign word_shift   = {in_byte, word_reg[31:8]};
    assign name_shift   = {in_byte, name_reg[31:8]};
    assign skip_len     = (word_shift + 32'd1) & ~32'd1;
    // the divider starts on the last data header byte, so take the length
    // straight from the byte being shifted in
    assign len_by_width = {1'b0, word_shift[30:0]};

    always_comb
    begin
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        name_next  = name_reg;
        flen_next  = flen_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        width_next = width_reg;
        drem_next  = drem_reg;
        low_next   = low_reg;
        if (cmd.shift_name)
            name_next = name_shift;
        if (cmd.shift_word)
            word_next = word_shift;
        if (cmd.clear_word)
            word_next = '0;
        if (cmd.cnt_clear)
            cnt_next = '0;
        if (cmd.cnt_inc)
            cnt_next = cnt_reg + 32'd1;
        if (cmd.cnt_dec)
            cnt_next = cnt_reg - 32'd1;
        if (cmd.cnt_load_skip)
            cnt_next = skip_len;
        if (cmd.cnt_load_excess)
            cnt_next = {1'b0, flen_reg} - 32'd16;
        if (cmd.save_fmt_len)
            flen_next = word_shift[30:0];
        if (cmd.save_channels)
            chan_next = word_shift[31:16];
        if (cmd.save_rate)
            rate_next = word_shift;
        if (cmd.save_width)
            width_next = word_shift[20] ? 2'd2 : 2'd1;
        if (cmd.save_data_len)
            drem_next = word_shift[30:0];
        if (cmd.data_dec)
            drem_next = drem_reg - 31'd1;
        if (cmd.hold_low)
            low_next = in_byte;
        if (cmd.reset_all)
        begin
            cnt_next   = '0;
            word_next  = '0;
            name_next  = '0;
            flen_next  = '0;
            chan_next  = '0;
            rate_next  = '0;
            width_next = '0;
            drem_next  = '0;
            low_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            word_reg  <= '0;
            name_reg  <= '0;
            flen_reg  <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            width_reg <= '0;
            drem_reg  <= '0;
            low_reg   <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            word_reg  <= word_next;
            name_reg  <= name_next;
            flen_reg  <= flen_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            width_reg <= width_next;
            drem_reg  <= drem_next;
            low_reg   <= low_next;
        end
    end

    // frames = (len / width) / channels; width is 1 or 2, so a shift
    rwhp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (width_reg[1] ? (len_by_width >> 1) : len_by_width),
        .divisor  (chan_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        stat.cnt_low      = cnt_reg[3:0];
        stat.cnt_zero     = (cnt_reg == 32'd0);
        stat.cnt_one      = (cnt_reg == 32'd1);
        stat.name_is_fmt  = (name_reg == rwhp_pkg::TAG_FMT);
        stat.name_is_data = (name_reg == rwhp_pkg::TAG_DATA);
        stat.pre_ok       = (name_reg == rwhp_pkg::TAG_RIFF)
                            && (word_shift == rwhp_pkg::TAG_WAVE);
        stat.len_neg      = word_shift[31];
        stat.skip_zero    = (skip_len == 32'd0);
        stat.fmt_tag_pcm  = (word_shift[31:16] == 16'd1);
        stat.next_upper   = word_shift[31:16];
        stat.fmt_long     = (flen_reg > 31'd16);
        stat.width_two    = (width_reg == 2'd2);
        stat.chan_zero    = (chan_reg == 16'd0) || (width_reg == 2'd0);
        stat.data_one     = (drem_reg == 31'd1);
        stat.data_zero    = (drem_reg == 31'd0);
        stat.cnt_odd      = cnt_reg[0];
        stat.div_busy     = div_busy;
        stat.div_done     = div_done;
        stat.frames_zero  = (div_quo == 32'd0);
    end

    assign channels = chan_reg;
    assign rate     = rate_reg;
    assign width    = width_reg;
    assign frames   = div_quo;
    assign low_byte = low_reg;
endmodule

FILE: sv/rwhp_control.sv
module rwhp_control (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rwhp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rwhp_pkg::out_item_t  out_data,
    output rwhp_pkg::rwhp_cmd_t  cmd,
    input  rwhp_pkg::rwhp_stat_t stat,
    input  logic [15:0]          channels,
    input  logic [31:0]          rate,
    input  logic [1:0]           width,
    input  logic [31:0]          frames,
    input  logic [7:0]           low_byte
);
    typedef enum logic [3:0] {
        ST_PREAMBLE,
        ST_FMT_HDR,
        ST_FMT_SKIP,
        ST_FMT_BODY,
        ST_FMT_EXCESS,
        ST_DATA_HDR,
        ST_DATA_SKIP,
        ST_DIVIDE,
        ST_SAMPLES,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                ovalid_reg, ovalid_next;
    rwhp_pkg::out_item_t odata_reg, odata_next;
    logic                eof_pend_reg, eof_pend_next;
    logic                accept;
    logic                slot_free;
    logic                emit;
    logic                err;
    rwhp_pkg::out_item_t res;
    logic [15:0]         bits;

    assign slot_free = !ovalid_reg || out_ready;
    // one result slot; hold off input while the divider runs
    assign in_ready  = slot_free && (state_reg != ST_DIVIDE);
    assign accept    = in_valid && in_ready;
    assign bits      = stat.next_upper;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        eof_pend_next = eof_pend_reg;
        emit          = 1'b0;
        err           = 1'b0;
        res           = '0;
        ovalid_next   = ovalid_reg && !out_ready;
        odata_next    = odata_reg;

        if (state_reg == ST_DIVIDE)
        begin
            if (stat.div_done && slot_free)
            begin
                if (stat.frames_zero)
                begin
                    res.result_kind = rwhp_pkg::KIND_ERROR;
                    res.error_code  = rwhp_pkg::ERR_ZERO;
                    err             = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    res.result_kind   = rwhp_pkg::KIND_HEADER;
                    res.channel_count = channels;
                    res.sample_rate   = rate[30:0];
                    res.sample_width  = width;
                    res.frame_count   = frames[30:0];
                    state_next        = ST_SAMPLES;
                end
                emit = 1'b1;
                if (eof_pend_reg)
                begin
                    // the data header byte carried end of file
                    if (!err)
                    begin
                        res            = '0;
                        res.result_kind = rwhp_pkg::KIND_ERROR;
                        res.error_code  = rwhp_pkg::ERR_NO_DATA;
                    end
                    cmd.reset_all = 1'b1;
                    state_next    = ST_PREAMBLE;
                end
                eof_pend_next = 1'b0;
            end
        end
        else if (accept)
        begin
            case (state_reg)
                ST_PREAMBLE:
                begin
                    if (stat.cnt_low < 4'd4)
                        cmd.shift_name = 1'b1;
                    else
                        cmd.shift_word = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (stat.cnt_low == 4'd11)
                    begin
                        cmd.cnt_inc   = 1'b0;
                        cmd.cnt_clear = 1'b1;
                        if (stat.pre_ok)
                            state_next = ST_FMT_HDR;
                        else
                        begin
                            res.result_kind = rwhp_pkg::KIND_ERROR;
                            res.error_code  = rwhp_pkg::ERR_NO_RIFF;
                            emit = 1'b1; err = 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                end
                ST_FMT_HDR, ST_DATA_HDR:
                begin
                    if (stat.cnt_low < 4'd4)
                        cmd.shift_name = 1'b1;
                    else
                        cmd.shift_word = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (stat.cnt_low == 4'd7)
                    begin
                        cmd.cnt_inc   = 1'b0;
                        cmd.cnt_clear = 1'b1;
                        if (stat.len_neg)
                        begin
                            res.result_kind = rwhp_pkg::KIND_ERROR;
                            res.error_code  = rwhp_pkg::ERR_NEG_LEN;
                            emit = 1'b1; err = 1'b1;
                            state_next = ST_DONE;
                        end
                        else if (state_reg == ST_FMT_HDR && stat.name_is_fmt)
                        begin
                            cmd.save_fmt_len = 1'b1;
                            cmd.shift_word   = 1'b0;
                            cmd.clear_word   = 1'b1;
                            state_next       = ST_FMT_BODY;
                        end
                        else if (state_reg == ST_DATA_HDR && stat.name_is_data)
                        begin
                            cmd.save_data_len = 1'b1;
                            if (stat.chan_zero)
                            begin
                                res.result_kind = rwhp_pkg::KIND_ERROR;
                                res.error_code  = rwhp_pkg::ERR_ZERO;
                                emit = 1'b1; err = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                                state_next = ST_DIVIDE;
                        end
                        else if (!stat.skip_zero)
                        begin
                            cmd.cnt_clear     = 1'b0;
                            cmd.cnt_load_skip = 1'b1;
                            state_next = (state_reg == ST_FMT_HDR) ? ST_FMT_SKIP
                                                                  : ST_DATA_SKIP;
                        end
                    end
                end
                ST_FMT_SKIP, ST_DATA_SKIP, ST_FMT_EXCESS:
                begin
                    if (!stat.cnt_zero)
                        cmd.cnt_dec = 1'b1;
                    if (stat.cnt_zero || stat.cnt_one)
                        state_next = (state_reg == ST_FMT_SKIP) ? ST_FMT_HDR
                                                               : ST_DATA_HDR;
                end
                ST_FMT_BODY:
                begin
                    cmd.shift_word = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    if (stat.cnt_low == 4'd1)
                    begin
                        if (!stat.fmt_tag_pcm)
                        begin
                            res.result_kind = rwhp_pkg::KIND_ERROR;
                            res.error_code  = rwhp_pkg::ERR_NOT_PCM;
                            emit = 1'b1; err = 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                    else if (stat.cnt_low == 4'd3)
                        cmd.save_channels = 1'b1;
                    else if (stat.cnt_low == 4'd7)
                        cmd.save_rate = 1'b1;
                    else if (stat.cnt_low == 4'd15)
                    begin
                        cmd.cnt_inc   = 1'b0;
                        cmd.cnt_clear = 1'b1;
                        if (bits != 16'd8 && bits != 16'd16)
                        begin
                            res.result_kind = rwhp_pkg::KIND_ERROR;
                            res.error_code  = rwhp_pkg::ERR_BAD_BITS;
                            emit = 1'b1; err = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.save_width = 1'b1;
                            if (stat.fmt_long)
                            begin
                                cmd.cnt_clear       = 1'b0;
                                cmd.cnt_load_excess = 1'b1;
                                state_next          = ST_FMT_EXCESS;
                            end
                            else
                                state_next = ST_DATA_HDR;
                        end
                    end
                end
                ST_SAMPLES:
                begin
                    if (stat.data_zero)
                        state_next = ST_DONE;
                    else
                    begin
                        cmd.data_dec = 1'b1;
                        res.result_kind  = rwhp_pkg::KIND_SAMPLE;
                        res.sample_width = width;
                        if (!stat.width_two)
                        begin
                            res.sample_value = {8'd0, in_data.in_byte};
                            res.end_of_data  = stat.data_one;
                            emit = 1'b1;
                        end
                        else if (!stat.cnt_odd)
                        begin
                            cmd.hold_low = 1'b1;
                            cmd.cnt_inc  = 1'b1;
                            res.sample_value = {8'd0, in_data.in_byte};
                            res.end_of_data  = 1'b1;
                            emit = stat.data_one;
                        end
                        else
                        begin
                            cmd.cnt_inc = 1'b1;
                            res.sample_value = {in_data.in_byte, low_byte};
                            res.end_of_data  = stat.data_one;
                            emit = 1'b1;
                        end
                        if (stat.data_one)
                            state_next = ST_DONE;
                    end
                end
                default:
                begin
                end
            endcase

            if (in_data.end_of_file)
            begin
                if (state_next == ST_DIVIDE)
                    eof_pend_next = 1'b1;
                else
                begin
                    if (!err && state_next != ST_DONE)
                    begin
                        res = '0;
                        res.result_kind = rwhp_pkg::KIND_ERROR;
                        if (state_next == ST_PREAMBLE)
                            res.error_code = rwhp_pkg::ERR_NO_RIFF;
                        else if (state_next == ST_FMT_HDR || state_next == ST_FMT_SKIP
                                 || state_next == ST_FMT_BODY)
                            res.error_code = rwhp_pkg::ERR_NO_FMT;
                        else
                            res.error_code = rwhp_pkg::ERR_NO_DATA;
                        emit = 1'b1;
                    end
                    cmd = '0;
                    cmd.reset_all = 1'b1;
                    state_next    = ST_PREAMBLE;
                end
            end
            if (state_next == ST_DIVIDE)
                cmd.div_start = 1'b1;
        end

        if (emit)
        begin
            ovalid_next = 1'b1;
            odata_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_PREAMBLE;
            ovalid_reg   <= 1'b0;
            eof_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ovalid_reg   <= ovalid_next;
            eof_pend_reg <= eof_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
endmodule

FILE: sv/riff_wave_header_parser_top.sv
// RIFF/WAVE PCM header parser.
// Input channel (in_valid/in_ready/in_data) takes one file byte per
// transaction together with an end-of-file flag on the last byte.
// Output channel (out_valid/out_ready/out_data) gives at most one result
// per byte: header info when the data chunk header ends, then one audio
// sample per sample (16-bit little-endian or raw 8-bit), or an error code.
// Each result is registered and shows in the cycle after its byte.
// Throughput: one byte per cycle while the output register drains. At the
// data chunk header the frame count division runs in a bit-serial divider;
// the header info is registered once the divider is done, and input is
// held until then.
// After an error, bytes are dropped up to the end-of-file byte; after the
// end-of-file byte the state returns to its reset value for the next file.
// A stalled receiver holds the result register, which in turn holds off
// input; nothing is lost or repeated.
// Reset (rst_n low) clears all parsing state and empties the output.
module riff_wave_header_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rwhp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rwhp_pkg::out_item_t out_data
);
    rwhp_pkg::rwhp_cmd_t  cmd;
    rwhp_pkg::rwhp_stat_t stat;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [1:0]  width;
    logic [31:0] frames;
    logic [7:0]  low_byte;

    rwhp_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat),
        .channels  (channels),
        .rate      (rate),
        .width     (width),
        .frames    (frames),
        .low_byte  (low_byte)
    );

    rwhp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_data.in_byte),
        .cmd      (cmd),
        .stat     (stat),
        .channels (channels),
        .rate     (rate),
        .width    (width),
        .frames   (frames),
        .low_byte (low_byte)
    );
endmodule
